// ===== hw/rtl/bpa_pkg.sv =====
package bpa_pkg;

    localparam int NUM_PAGES      = 4096;
    localparam int RESERVED_PAGES = 1;
    localparam int PAGE_W         = $clog2(NUM_PAGES);
    localparam int LEN_W          = PAGE_W + 1;
    localparam int BYTE_W         = PAGE_W - 3;
    localparam int MAP_BYTES      = NUM_PAGES / 8;
    localparam int PTR_W          = BYTE_W + 1;

    localparam logic [7:0] FULL_BYTE = 8'hFF;

    localparam logic [1:0] OP_ALLOC_ONE = 2'd0;
    localparam logic [1:0] OP_ALLOC_RUN = 2'd1;
    localparam logic [1:0] OP_FREE_ONE  = 2'd2;
    localparam logic [1:0] OP_FREE_RUN  = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_BAD      = 2'd2;

    typedef enum logic [1:0] {
        CMD_ALLOC_ONE,
        CMD_ALLOC_RUN,
        CMD_FREE,
        CMD_REJECT
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [PAGE_W-1:0]   page;
        logic [LEN_W-1:0]    len;
    } cmd_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_RUN,
        S_MOD,
        S_DONE
    } back_state_t;

    // index of the lowest clear bit, 0 when the byte is full
    function automatic logic [2:0] lowest_zero(input logic [7:0] x);
        logic [2:0] r;
        logic       hit;
        r   = 3'd0;
        hit = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!hit && !x[i]) begin
                r   = 3'(i);
                hit = 1'b1;
            end
        end
        return r;
    endfunction

    // bitmap byte at reset: pages below the reserved count are used
    function automatic logic [7:0] reserved_byte(input logic [BYTE_W-1:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = ({1'b0, b, 3'(i)} < (PAGE_W+1)'(RESERVED_PAGES));
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bpa_front.sv =====
module bpa_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [bpa_pkg::PAGE_W-1:0]  s_page_index,
    input  logic [bpa_pkg::LEN_W-1:0]   s_run_length,
    input  logic                        init_done,
    output logic                        cmd_valid,
    input  logic                        cmd_ready,
    output bpa_pkg::cmd_t               cmd
);
    import bpa_pkg::*;

    cmd_t              q_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        cnt_reg, cnt_next;
    cmd_t              cls;
    logic [LEN_W-1:0]  n;
    logic [LEN_W:0]    reach;
    logic              push, pop;

    // classify the request word
    always_comb begin
        n     = (s_op == OP_FREE_ONE) ? LEN_W'(1) : s_run_length;
        reach = (LEN_W+1)'(s_page_index) + (LEN_W+1)'(n);
        cls.page = s_page_index;
        cls.len  = n;
        unique case (s_op)
            OP_ALLOC_ONE: cls.kind = CMD_ALLOC_ONE;
            OP_ALLOC_RUN: begin
                if (s_run_length == '0 || s_run_length > LEN_W'(NUM_PAGES))
                    cls.kind = CMD_REJECT;
                else
                    cls.kind = CMD_ALLOC_RUN;
            end
            default: begin
                if (n == '0 || s_page_index < PAGE_W'(RESERVED_PAGES)
                    || reach > (LEN_W+1)'(NUM_PAGES))
                    cls.kind = CMD_REJECT;
                else
                    cls.kind = CMD_FREE;
            end
        endcase
    end

    assign s_ready   = init_done && (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== hw/rtl/bpa_back.sv =====
module bpa_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cmd_valid,
    output logic                        cmd_ready,
    input  bpa_pkg::cmd_t               cmd,
    output logic                        init_done,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bpa_pkg::PAGE_W-1:0]  m_first_page,
    output logic [1:0]                  m_status
);
    import bpa_pkg::*;

    logic [7:0] mem [MAP_BYTES];

    back_state_t        state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [PTR_W-1:0]   ptr_reg, ptr_next;
    logic [PTR_W-1:0]   lim_reg, lim_next;
    logic               dv_reg;
    logic [BYTE_W-1:0]  db_reg;
    logic [7:0]         rdata_reg;
    logic [PAGE_W-1:0]  hint_reg, hint_next;
    logic               pend_reg, pend_next;
    logic [LEN_W-1:0]   cnt_reg, cnt_next;
    logic [PAGE_W-1:0]  rfirst_reg, rfirst_next;
    logic [PAGE_W-1:0]  mlo_reg, mlo_next;
    logic [PAGE_W-1:0]  mhi_reg, mhi_next;
    logic               mset_reg, mset_next;
    logic [PAGE_W-1:0]  res_first_reg, res_first_next;
    logic [1:0]         res_status_reg, res_status_next;
    logic               m_valid_reg, m_valid_next;
    logic [PAGE_W-1:0]  m_first_reg, m_first_next;
    logic [1:0]         m_status_reg, m_status_next;

    logic               issue, flush, we;
    logic [BYTE_W-1:0]  waddr;
    logic [7:0]         wdata, x, y, mask;
    logic [LEN_W-1:0]   c, span;
    logic [PAGE_W-1:0]  f;
    logic               hit, free_b, last_byte, first_byte;
    logic [PAGE_W-1:0]  pg;

    assign init_done    = (state_reg != S_CLEAR);
    assign m_valid      = m_valid_reg;
    assign m_first_page = m_first_reg;
    assign m_status     = m_status_reg;

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ptr_next        = ptr_reg;
        lim_next        = lim_reg;
        hint_next       = hint_reg;
        pend_next       = pend_reg;
        cnt_next        = cnt_reg;
        rfirst_next     = rfirst_reg;
        mlo_next        = mlo_reg;
        mhi_next        = mhi_reg;
        mset_next       = mset_reg;
        res_first_next  = res_first_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_first_next    = m_first_reg;
        m_status_next   = m_status_reg;
        cmd_ready       = 1'b0;
        flush           = 1'b0;
        we              = 1'b0;
        waddr           = db_reg;
        wdata           = rdata_reg;
        x               = rdata_reg;
        y               = '0;
        mask            = '0;
        c               = cnt_reg;
        f               = rfirst_reg;
        hit             = 1'b0;
        free_b          = 1'b0;
        pg              = '0;
        span            = '0;
        last_byte       = (db_reg == BYTE_W'(MAP_BYTES - 1));
        first_byte      = (db_reg == hint_reg[PAGE_W-1:3]);

        // streaming byte reads, one per cycle, up to the phase limit
        issue = (state_reg == S_SCAN || state_reg == S_RUN || state_reg == S_MOD)
                && (ptr_reg <= lim_reg);
        if (issue) begin
            ptr_next = ptr_reg + PTR_W'(1);
        end

        unique case (state_reg)
            S_CLEAR: begin
                we       = 1'b1;
                waddr    = ptr_reg[BYTE_W-1:0];
                wdata    = reserved_byte(ptr_reg[BYTE_W-1:0]);
                ptr_next = ptr_reg + PTR_W'(1);
                if (ptr_reg == PTR_W'(MAP_BYTES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd_ready = 1'b1;
                if (cmd_valid) begin
                    cmd_next       = cmd;
                    res_first_next = '0;
                    unique case (cmd.kind)
                        CMD_REJECT: begin
                            res_status_next = ST_BAD;
                            state_next      = S_DONE;
                        end
                        CMD_ALLOC_ONE, CMD_ALLOC_RUN: begin
                            if (hint_reg == '0) begin
                                res_status_next = ST_NO_SPACE;
                                state_next      = S_DONE;
                            end else begin
                                ptr_next    = PTR_W'(hint_reg[PAGE_W-1:3]);
                                lim_next    = PTR_W'(MAP_BYTES - 1);
                                pend_next   = 1'b1;
                                cnt_next    = '0;
                                state_next  = (cmd.kind == CMD_ALLOC_ONE) ? S_SCAN : S_RUN;
                            end
                        end
                        CMD_FREE: begin
                            span       = LEN_W'(cmd.page) + cmd.len - LEN_W'(1);
                            mlo_next   = cmd.page;
                            mhi_next   = span[PAGE_W-1:0];
                            mset_next  = 1'b0;
                            ptr_next   = PTR_W'(cmd.page[PAGE_W-1:3]);
                            lim_next   = PTR_W'(span[PAGE_W-1:3]);
                            state_next = S_MOD;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (dv_reg) begin
                    if (pend_reg) begin
                        // still looking for the page to hand out
                        if (x != FULL_BYTE) begin
                            mask            = 8'b1 << lowest_zero(x);
                            y               = x | mask;
                            we              = 1'b1;
                            wdata           = y;
                            res_first_next  = {db_reg, lowest_zero(x)};
                            res_status_next = ST_OK;
                            if (y != FULL_BYTE) begin
                                hint_next  = {db_reg, lowest_zero(y)};
                                flush      = 1'b1;
                                state_next = S_DONE;
                            end else if (last_byte) begin
                                hint_next  = '0;
                                flush      = 1'b1;
                                state_next = S_DONE;
                            end else begin
                                pend_next = 1'b0;
                            end
                        end else if (last_byte) begin
                            res_first_next  = '0;
                            res_status_next = ST_NO_SPACE;
                            flush           = 1'b1;
                            state_next      = S_DONE;
                        end
                    end else begin
                        // hint search
                        if (x != FULL_BYTE) begin
                            hint_next  = {db_reg, lowest_zero(x)};
                            flush      = 1'b1;
                            state_next = S_DONE;
                        end else if (last_byte) begin
                            hint_next  = '0;
                            flush      = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_RUN: begin
                if (dv_reg) begin
                    for (int i = 0; i < 8; i++) begin
                        // pages below the hint in its byte count as used
                        free_b = !x[i] && !(first_byte && (3'(i) < hint_reg[2:0]));
                        if (!hit) begin
                            if (free_b) begin
                                if (c == '0) begin
                                    f = {db_reg, 3'(i)};
                                end
                                c = c + LEN_W'(1);
                                if (c == cmd_reg.len) begin
                                    hit = 1'b1;
                                end
                            end else begin
                                c = '0;
                            end
                        end
                    end
                    cnt_next    = c;
                    rfirst_next = f;
                    if (hit) begin
                        span            = LEN_W'(f) + cmd_reg.len - LEN_W'(1);
                        res_first_next  = f;
                        res_status_next = ST_OK;
                        mlo_next        = f;
                        mhi_next        = span[PAGE_W-1:0];
                        mset_next       = 1'b1;
                        ptr_next        = PTR_W'(f[PAGE_W-1:3]);
                        lim_next        = PTR_W'(span[PAGE_W-1:3]);
                        flush           = 1'b1;
                        state_next      = S_MOD;
                    end else if (last_byte) begin
                        res_first_next  = '0;
                        res_status_next = ST_NO_SPACE;
                        flush           = 1'b1;
                        state_next      = S_DONE;
                    end
                end
            end
            S_MOD: begin
                if (dv_reg) begin
                    for (int i = 0; i < 8; i++) begin
                        pg      = {db_reg, 3'(i)};
                        mask[i] = (pg >= mlo_reg) && (pg <= mhi_reg);
                    end
                    we    = 1'b1;
                    wdata = mset_reg ? (x | mask) : (x & ~mask);
                    if (db_reg == mhi_reg[PAGE_W-1:3]) begin
                        flush = 1'b1;
                        if (mset_reg) begin
                            // rescan the hint from its old byte
                            ptr_next   = PTR_W'(hint_reg[PAGE_W-1:3]);
                            lim_next   = PTR_W'(MAP_BYTES - 1);
                            pend_next  = 1'b0;
                            state_next = S_SCAN;
                        end else begin
                            res_first_next  = mlo_reg;
                            res_status_next = ST_OK;
                            if (hint_reg == '0 || mlo_reg < hint_reg) begin
                                hint_next = mlo_reg;
                            end
                            state_next = S_DONE;
                        end
                    end
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_first_next  = res_first_reg;
                    m_status_next = res_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            ptr_reg     <= '0;
            dv_reg      <= 1'b0;
            hint_reg    <= PAGE_W'(RESERVED_PAGES);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            dv_reg      <= issue && !flush;
            hint_reg    <= hint_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        lim_reg        <= lim_next;
        pend_reg       <= pend_next;
        cnt_reg        <= cnt_next;
        rfirst_reg     <= rfirst_next;
        mlo_reg        <= mlo_next;
        mhi_reg        <= mhi_next;
        mset_reg       <= mset_next;
        res_first_reg  <= res_first_next;
        res_status_reg <= res_status_next;
        m_first_reg    <= m_first_next;
        m_status_reg   <= m_status_next;
        db_reg         <= ptr_reg[BYTE_W-1:0];
    end

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (issue) begin
            rdata_reg <= mem[ptr_reg[BYTE_W-1:0]];
        end
    end

endmodule

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Bitmap page allocator, first fit over a byte-wide used-page bitmap.
// Input channel s_*: one request word per transfer (op, page_index,
// run_length); op 0 allocates one page, 1 allocates a run, 2 frees one
// page, 3 frees a run. Output channel m_*: one result word per request,
// first_page and status (0 ok, 1 no space, 2 bad request), in order.
// A front stage classifies requests and checks their ranges into a
// two-entry queue; the back stage walks the bitmap memory one byte per
// cycle through its single read port and single write port.
// A rejected request passes from the queue straight to S_DONE and m_*;
// an allocation or free first reads each bitmap byte that it visits.
// A single-page allocate walks from the hint byte to the next free page
// after it; a run allocate walks to the fitting run, marks it, then
// rescans the hint. Requests are worked one at a time; the queue accepts
// up to two more meanwhile.
// Reset: aresetn low clears control; after release a pass over all 512
// bitmap bytes writes the bitmap (reserved pages used) with s_ready held low.
// If the receiver stalls, the result is held in m_* and the back stage
// waits once its next result is ready; the queue then fills and s_ready drops.
module bitmap_page_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [1:0]                  s_op,
    input  logic [bpa_pkg::PAGE_W-1:0]  s_page_index,
    input  logic [bpa_pkg::LEN_W-1:0]   s_run_length,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bpa_pkg::PAGE_W-1:0]  m_first_page,
    output logic [1:0]                  m_status
);
    import bpa_pkg::*;

    logic  cmd_valid;
    logic  cmd_ready;
    cmd_t  cmd;
    logic  init_done;

    bpa_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_page_index (s_page_index),
        .s_run_length (s_run_length),
        .init_done    (init_done),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd)
    );

    bpa_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .init_done    (init_done),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_first_page (m_first_page),
        .m_status     (m_status)
    );

endmodule
